/* rtl/kda_pkg.sv */
// Shared types and constants for the key debounce and auto-repeat block.
package kda_pkg;

    // Width of a key bitmap as it travels on the ports.
    localparam int unsigned KEY_W = 8;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_DEBOUNCE_TICKS = 2'd0,
        REG_REPEAT_TICKS   = 2'd1,
        REG_REPEAT_MODE    = 2'd2
    } kda_reg_idx_t;

    // Input item kinds.
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] DEBOUNCE_TICKS_RST = 8'd50;
    localparam logic [7:0] REPEAT_TICKS_RST   = 8'd200;

    // Acceleration constants of the repeat interval.
    localparam logic [7:0] BOOST_SMALL_STEP  = 8'd2;
    localparam logic [7:0] BOOST_SMALL_LIMIT = 8'd10;
    localparam logic [7:0] BOOST_LARGE_STEP  = 8'd10;
    localparam logic [8:0] BOOST_MARGIN      = 9'd40;

    // One input beat.
    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key_sample;
        logic [KEY_W-1:0] key_mask;
    } kda_in_t;

    // One result beat.
    typedef struct packed {
        logic             pressed;
        logic [KEY_W-1:0] latched_keys;
        logic [1:0]       phase;
    } kda_out_t;

    // Configuration as seen by the scanner core.
    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [7:0] repeat_ticks;
        logic       repeat_mode;
    } kda_cfg_t;

endpackage

/* rtl/kda_core.sv */
// Scanner core: debounce, click and accelerating repeat state, one item per cycle while step is high.
module kda_core #(
    parameter int unsigned KEY_COUNT = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  kda_pkg::kda_in_t  item,
    input  kda_pkg::kda_cfg_t cfg,
    output kda_pkg::kda_out_t result
);
    import kda_pkg::*;

    // Only the low KEY_COUNT bits of a bitmap take part.
    localparam logic [KEY_W-1:0] KeyMask = (KEY_COUNT >= KEY_W) ? {KEY_W{1'b1}}
                                         : KEY_W'((1 << KEY_COUNT) - 1);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_CLICK    = 2'd2,
        PH_REPEAT   = 2'd3
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [KEY_W-1:0] latch_reg, latch_next;
    logic [7:0]       dcount_reg, dcount_next;
    logic [7:0]       rcount_reg, rcount_next;
    logic [7:0]       boost_reg, boost_next;

    logic [KEY_W-1:0] sample;
    logic [KEY_W-1:0] mask;
    logic             sample_any;
    logic [7:0]       dcount_dec;
    logic [7:0]       rcount_dec;
    logic [7:0]       db_reload;
    logic [7:0]       rt_reload;
    logic [8:0]       rt_diff;
    logic [7:0]       rep_reload;
    logic [7:0]       boost_grow;
    logic             run_repeat;
    logic             pressed;

    // Reload values, saturated so that a counter never loads zero, and the next boost.
    always_comb
    begin
        db_reload  = (cfg.debounce_ticks == 8'd0) ? 8'd1 : cfg.debounce_ticks;
        rt_reload  = (cfg.repeat_ticks == 8'd0) ? 8'd1 : cfg.repeat_ticks;
        rt_diff    = {1'b0, cfg.repeat_ticks} - {1'b0, boost_reg};
        rep_reload = (rt_diff[8] || rt_diff == 9'd0) ? 8'd1 : rt_diff[7:0];
        if (boost_reg < BOOST_SMALL_LIMIT)
        begin
            boost_grow = boost_reg + BOOST_SMALL_STEP;
        end
        else if (({1'b0, boost_reg} + BOOST_MARGIN) < {1'b0, cfg.repeat_ticks})
        begin
            boost_grow = boost_reg + BOOST_LARGE_STEP;
        end
        else
        begin
            boost_grow = boost_reg;
        end
    end

    // Next state for one tick or query.
    always_comb
    begin
        sample      = item.key_sample & KeyMask;
        mask        = item.key_mask & KeyMask;
        sample_any  = |sample;
        dcount_dec  = dcount_reg - 8'd1;
        rcount_dec  = rcount_reg - 8'd1;
        phase_next  = phase_reg;
        latch_next  = latch_reg;
        dcount_next = dcount_reg;
        rcount_next = rcount_reg;
        boost_next  = boost_reg;
        run_repeat  = 1'b0;
        pressed     = 1'b0;

        if (item.mode == MODE_QUERY)
        begin
            // A query reads and clears the masked latched keys.
            if ((latch_reg & mask) != '0)
            begin
                latch_next = latch_reg & ~mask;
                pressed    = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE, PH_DEBOUNCE:
                begin
                    if (!sample_any)
                    begin
                        // A release aborts debouncing and leaves the latch alone.
                        if (phase_reg == PH_DEBOUNCE)
                        begin
                            dcount_next = db_reload;
                            phase_next  = PH_IDLE;
                        end
                    end
                    else if (dcount_dec != 8'd0)
                    begin
                        dcount_next = dcount_dec;
                        phase_next  = PH_DEBOUNCE;
                    end
                    else
                    begin
                        // Debounce done: latch, then click or start repeating.
                        dcount_next = db_reload;
                        latch_next  = sample;
                        if (cfg.repeat_mode)
                        begin
                            phase_next = PH_REPEAT;
                            run_repeat = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_CLICK;
                        end
                    end
                end
                PH_CLICK:
                begin
                    if (!sample_any)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_REPEAT:
                begin
                    run_repeat = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // Repeat counter, also on the tick that finishes debouncing.
            if (run_repeat)
            begin
                if (!sample_any)
                begin
                    boost_next  = 8'd0;
                    rcount_next = rt_reload;
                    phase_next  = PH_IDLE;
                end
                else if (rcount_dec != 8'd0)
                begin
                    rcount_next = rcount_dec;
                end
                else
                begin
                    latch_next  = sample;
                    rcount_next = rep_reload;
                    boost_next  = boost_grow;
                end
            end
        end
    end

    // State registers advance once per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            latch_reg  <= '0;
            dcount_reg <= DEBOUNCE_TICKS_RST;
            rcount_reg <= REPEAT_TICKS_RST;
            boost_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            latch_reg  <= latch_next;
            dcount_reg <= dcount_next;
            rcount_reg <= rcount_next;
            boost_reg  <= boost_next;
        end
    end

    assign result.pressed      = pressed;
    assign result.latched_keys = latch_next;
    assign result.phase        = phase_next;

endmodule

/* rtl/key_debounce_autorepeat_top.sv */
// Top level of the key debounce and auto-repeat block: register port and result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in      | input     | in_valid/in_ready  | in_data  (mode, key_sample, key_mask)
//   out     | output    | out_valid/out_ready| out_data (pressed, latched_keys, phase)
//   apb     | input     | psel/penable       | paddr, pwdata, prdata
//
// Each beat's result appears in the output register the next cycle, and a new
// beat is taken each cycle while that register is empty or being drained.
// The only stall is a full output register with out_ready low. Reset clears
// the scanner state and the output valid; the registers return to their
// documented defaults.
module key_debounce_autorepeat_top #(
    parameter int unsigned KEY_COUNT = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             in_valid,
    output logic             in_ready,
    input  kda_pkg::kda_in_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output kda_pkg::kda_out_t out_data
);
    import kda_pkg::*;

    kda_cfg_t     cfg_reg;
    kda_reg_idx_t reg_idx;
    logic         wr_en;
    logic         step;
    kda_out_t     result;
    logic         out_valid_reg;
    kda_out_t     out_data_reg;

    assign pready  = 1'b1;
    assign reg_idx = kda_reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Configuration registers; addresses past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            cfg_reg.repeat_ticks   <= REPEAT_TICKS_RST;
            cfg_reg.repeat_mode    <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= pwdata[7:0];
                REG_REPEAT_TICKS:   cfg_reg.repeat_ticks   <= pwdata[7:0];
                REG_REPEAT_MODE:    cfg_reg.repeat_mode    <= pwdata[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            REG_DEBOUNCE_TICKS: prdata = {24'd0, cfg_reg.debounce_ticks};
            REG_REPEAT_TICKS:   prdata = {24'd0, cfg_reg.repeat_ticks};
            REG_REPEAT_MODE:    prdata = {31'd0, cfg_reg.repeat_mode};
            default:            prdata = 32'd0;
        endcase
    end

    // A beat is taken whenever the output register can hold its result.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    kda_core #(
        .KEY_COUNT (KEY_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
